[hdl/tcc_pkg.sv]
package tcc_pkg;

   localparam int CELL_SIZE = 8;
   localparam int TAB_STOP  = 64;

   localparam int SCREEN_BITS = 13;
   localparam int TOP_BITS    = 7;
   localparam int COLOR_BITS  = 32;
   localparam int POS_BITS    = 12;
   localparam int CHAR_BITS   = 8;
   localparam int MAX_CMDS    = 4;
   localparam int IDX_BITS    = 2;
   localparam int CNT_BITS    = 3;

   localparam logic [CHAR_BITS-1:0] CHAR_BS       = 8'd8;
   localparam logic [CHAR_BITS-1:0] CHAR_TAB      = 8'd9;
   localparam logic [CHAR_BITS-1:0] CHAR_LF       = 8'd10;
   localparam logic [CHAR_BITS-1:0] CHAR_FF       = 8'd12;
   localparam logic [CHAR_BITS-1:0] CHAR_CR       = 8'd13;
   localparam logic [CHAR_BITS-1:0] CHAR_PRINT_LO = 8'd32;
   localparam logic [CHAR_BITS-1:0] CHAR_PRINT_HI = 8'd126;

   localparam logic [2:0] REG_DISP_WIDTH    = 3'd0;
   localparam logic [2:0] REG_DISP_HEIGHT   = 3'd1;
   localparam logic [2:0] REG_RESERVED_TOP  = 3'd2;
   localparam logic [2:0] REG_TEXT_COLOR    = 3'd3;
   localparam logic [2:0] REG_BACK_COLOR    = 3'd4;

   localparam logic [SCREEN_BITS-1:0] RST_DISP_WIDTH    = 13'd640;
   localparam logic [SCREEN_BITS-1:0] RST_DISP_HEIGHT   = 13'd480;
   localparam logic [TOP_BITS-1:0]    RST_RESERVED_TOP  = 7'd8;
   localparam logic [COLOR_BITS-1:0]  RST_TEXT_COLOR    = 32'h00FF_FFFF;
   localparam logic [COLOR_BITS-1:0]  RST_BACK_COLOR    = 32'h0000_0000;

   typedef enum logic [2:0] {
      CMD_ERASE  = 3'd0,
      CMD_GLYPH  = 3'd1,
      CMD_SCROLL = 3'd2,
      CMD_CLEAR  = 3'd3,
      CMD_CURSOR = 3'd4
   } cmd_type;

   typedef struct packed {
      cmd_type [MAX_CMDS-1:0] cmd;
      logic [CNT_BITS-1:0]    count;
      logic [POS_BITS-1:0]    old_x;
      logic [POS_BITS-1:0]    old_y;
      logic [POS_BITS-1:0]    new_x;
      logic [POS_BITS-1:0]    new_y;
      logic [CHAR_BITS-1:0]   glyph;
   } cmd_list_type;

endpackage

[hdl/tcc_step.sv]
module tcc_step
   import tcc_pkg::*;
#(
   parameter int COORD_BITS = 13
) (
   input  logic [CHAR_BITS-1:0]   char_code,
   input  logic [COORD_BITS-1:0]  col,
   input  logic [COORD_BITS-1:0]  row,
   input  logic [SCREEN_BITS-1:0] disp_width,
   input  logic [SCREEN_BITS-1:0] disp_height,
   input  logic [TOP_BITS-1:0]    reserved_top,
   output logic [COORD_BITS-1:0]  col_next,
   output logic [COORD_BITS-1:0]  row_next,
   output cmd_list_type           list
);

   localparam int CW = ((COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS) + 1;

   always_comb begin
      logic [COORD_BITS-1:0] c;
      logic [COORD_BITS-1:0] r;
      logic [CW-1:0]         sum;
      logic [CW-1:0]         old_c_w;
      logic [CW-1:0]         old_r_w;
      logic [CW-1:0]         new_c_w;
      logic [CW-1:0]         new_r_w;
      logic                  wrap_chk;
      logic                  chk_scroll;
      logic                  add_glyph;
      logic                  add_clear;
      logic                  add_scroll;
      logic                  add_cursor;
      logic [CNT_BITS-1:0]   n;

      c          = col;
      r          = row;
      sum        = '0;
      wrap_chk   = 1'b0;
      chk_scroll = 1'b1;
      add_glyph  = 1'b0;
      add_clear  = 1'b0;

      case (char_code) inside
         CHAR_BS: begin
            if (c >= COORD_BITS'(CELL_SIZE)) c = c - COORD_BITS'(CELL_SIZE);
         end
         CHAR_TAB: begin
            // round up to the next tab stop
            sum      = CW'(col) + CW'(TAB_STOP - 1);
            c        = sum[COORD_BITS-1:0] & ~COORD_BITS'(TAB_STOP - 1);
            wrap_chk = 1'b1;
         end
         CHAR_LF: begin
            r = r + COORD_BITS'(CELL_SIZE);
            c = '0;
         end
         CHAR_FF: begin
            add_clear  = 1'b1;
            c          = '0;
            r          = COORD_BITS'(reserved_top);
            chk_scroll = 1'b0;
         end
         CHAR_CR: begin
            c = '0;
         end
         [CHAR_PRINT_LO:CHAR_PRINT_HI]: begin
            add_glyph = 1'b1;
            c         = c + COORD_BITS'(CELL_SIZE);
            wrap_chk  = 1'b1;
         end
         default: begin
         end
      endcase

      if (wrap_chk && (CW'(c) + CW'(CELL_SIZE) >= CW'(disp_width))) begin
         c = '0;
         r = r + COORD_BITS'(CELL_SIZE);
      end

      add_scroll = chk_scroll && (CW'(r) + CW'(1) >= CW'(disp_height));
      if (add_scroll) r = (r >= COORD_BITS'(CELL_SIZE)) ? r - COORD_BITS'(CELL_SIZE) : '0;

      add_cursor = (CW'(c) < CW'(disp_width)) && (CW'(r) < CW'(disp_height));

      col_next = c;
      row_next = r;

      old_c_w = CW'(col);
      old_r_w = CW'(row);
      new_c_w = CW'(c);
      new_r_w = CW'(r);

      // pack the run of commands in issue order
      list.cmd = {MAX_CMDS{CMD_ERASE}};
      n        = CNT_BITS'(1);
      if (add_glyph) begin
         list.cmd[n[IDX_BITS-1:0]] = CMD_GLYPH;
         n = n + CNT_BITS'(1);
      end
      if (add_clear) begin
         list.cmd[n[IDX_BITS-1:0]] = CMD_CLEAR;
         n = n + CNT_BITS'(1);
      end
      if (add_scroll) begin
         list.cmd[n[IDX_BITS-1:0]] = CMD_SCROLL;
         n = n + CNT_BITS'(1);
      end
      if (add_cursor) begin
         list.cmd[n[IDX_BITS-1:0]] = CMD_CURSOR;
         n = n + CNT_BITS'(1);
      end
      list.count = n - CNT_BITS'(1);
      list.old_x = old_c_w[POS_BITS-1:0];
      list.old_y = old_r_w[POS_BITS-1:0];
      list.new_x = new_c_w[POS_BITS-1:0];
      list.new_y = new_r_w[POS_BITS-1:0];
      list.glyph = char_code;
   end

endmodule

[hdl/tcc_emit.sv]
module tcc_emit
   import tcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  cmd_list_type          list_in,
   input  logic [COLOR_BITS-1:0] text_color,
   input  logic [COLOR_BITS-1:0] back_color,
   input  logic [TOP_BITS-1:0]   reserved_top,
   output logic                  can_load,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_command,
   output logic [POS_BITS-1:0]   rsp_pos_x,
   output logic [POS_BITS-1:0]   rsp_pos_y,
   output logic [CHAR_BITS-1:0]  rsp_glyph,
   output logic [COLOR_BITS-1:0] rsp_pixel_color,
   output logic                  rsp_last
);

   logic                busy_ff, busy_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   cmd_list_type        list_ff, list_in_sel;
   cmd_type             cur;
   logic                done;

   assign cur       = list_ff.cmd[idx_ff];
   assign rsp_valid = busy_ff;
   assign rsp_last  = (CNT_BITS'(idx_ff) == list_ff.count);
   assign done      = busy_ff && rsp_ready && rsp_last;
   assign can_load  = !busy_ff || done;

   always_comb begin
      busy_in     = busy_ff;
      idx_in      = idx_ff;
      list_in_sel = list_ff;
      if (busy_ff && rsp_ready) begin
         if (rsp_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + IDX_BITS'(1);
         end
      end
      if (load) begin
         busy_in     = 1'b1;
         idx_in      = '0;
         list_in_sel = list_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      list_ff <= list_in_sel;
   end

   always_comb begin
      rsp_command     = cur;
      rsp_glyph       = '0;
      rsp_pos_x       = '0;
      rsp_pos_y       = '0;
      rsp_pixel_color = back_color;
      case (cur)
         CMD_ERASE: begin
            rsp_pos_x = list_ff.old_x;
            rsp_pos_y = list_ff.old_y;
         end
         CMD_GLYPH: begin
            rsp_pos_x       = list_ff.old_x;
            rsp_pos_y       = list_ff.old_y;
            rsp_glyph       = list_ff.glyph;
            rsp_pixel_color = text_color;
         end
         CMD_SCROLL: begin
            rsp_pos_y = POS_BITS'(reserved_top);
         end
         CMD_CLEAR: begin
         end
         CMD_CURSOR: begin
            rsp_pos_x       = list_ff.new_x;
            rsp_pos_y       = list_ff.new_y;
            rsp_pixel_color = text_color;
         end
         default: begin
         end
      endcase
   end

endmodule

[hdl/text_console_cursor_controller.sv]
// Latency: a character accepted at one edge shows its first command the next cycle.
// Throughput: one command transfers per cycle while rsp_ready is high; a character causes
// 1 to 4 commands, and the single result register holds one character's run at a time.
// A new character is taken in the cycle its previous run's final command transfers.
// Reset (synchronous): cursor to column 0, row 8; registers to their reset values.
module text_console_cursor_controller
   import tcc_pkg::*;
#(
   parameter int COORD_BITS = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CHAR_BITS-1:0]  req_char_code,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_command,
   output logic [POS_BITS-1:0]   rsp_pos_x,
   output logic [POS_BITS-1:0]   rsp_pos_y,
   output logic [CHAR_BITS-1:0]  rsp_glyph,
   output logic [COLOR_BITS-1:0] rsp_pixel_color,
   output logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [4:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [SCREEN_BITS-1:0] disp_width_ff;
   logic [SCREEN_BITS-1:0] disp_height_ff;
   logic [TOP_BITS-1:0]    reserved_top_ff;
   logic [COLOR_BITS-1:0]  text_color_ff;
   logic [COLOR_BITS-1:0]  back_color_ff;
   logic [COORD_BITS-1:0]  col_ff, col_in;
   logic [COORD_BITS-1:0]  row_ff, row_in;
   logic [2:0]             reg_idx;
   logic                   wr_en;
   logic                   accept;
   logic                   can_load;
   cmd_list_type           list;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         disp_width_ff    <= RST_DISP_WIDTH;
         disp_height_ff   <= RST_DISP_HEIGHT;
         reserved_top_ff  <= RST_RESERVED_TOP;
         text_color_ff    <= RST_TEXT_COLOR;
         back_color_ff    <= RST_BACK_COLOR;
      end else if (wr_en) begin
         case (reg_idx)
            REG_DISP_WIDTH:    disp_width_ff    <= pwdata[SCREEN_BITS-1:0];
            REG_DISP_HEIGHT:   disp_height_ff   <= pwdata[SCREEN_BITS-1:0];
            REG_RESERVED_TOP:  reserved_top_ff  <= pwdata[TOP_BITS-1:0];
            REG_TEXT_COLOR:    text_color_ff    <= pwdata;
            REG_BACK_COLOR:    back_color_ff    <= pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_DISP_WIDTH:    prdata = 32'(disp_width_ff);
         REG_DISP_HEIGHT:   prdata = 32'(disp_height_ff);
         REG_RESERVED_TOP:  prdata = 32'(reserved_top_ff);
         REG_TEXT_COLOR:    prdata = text_color_ff;
         REG_BACK_COLOR:    prdata = back_color_ff;
         default:           prdata = '0;
      endcase
   end

   assign req_ready = can_load;
   assign accept    = req_valid && can_load;

   tcc_step #(
      .COORD_BITS(COORD_BITS)
   ) u_step (
      .char_code     (req_char_code),
      .col           (col_ff),
      .row           (row_ff),
      .disp_width    (disp_width_ff),
      .disp_height   (disp_height_ff),
      .reserved_top  (reserved_top_ff),
      .col_next      (col_in),
      .row_next      (row_in),
      .list          (list)
   );

   // advance the cursor once per accepted character
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= COORD_BITS'(RST_RESERVED_TOP);
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   tcc_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .load            (accept),
      .list_in         (list),
      .text_color      (text_color_ff),
      .back_color      (back_color_ff),
      .reserved_top    (reserved_top_ff),
      .can_load        (can_load),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_command     (rsp_command),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_glyph       (rsp_glyph),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last)
   );

endmodule

[hdl/tcc_checker.sv]
module tcc_checker
   import tcc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [2:0]            rsp_command,
   input logic [POS_BITS-1:0]   rsp_pos_x,
   input logic [POS_BITS-1:0]   rsp_pos_y,
   input logic [CHAR_BITS-1:0]  rsp_glyph,
   input logic [COLOR_BITS-1:0] rsp_pixel_color,
   input logic                  rsp_last
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_command) && $stable(rsp_pos_x)
         && $stable(rsp_pos_y) && $stable(rsp_glyph) && $stable(rsp_pixel_color)
         && $stable(rsp_last))
      else $error("result changed while stalled");

   // a character's run opens with an erase in the next cycle
   a_req_erase: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid && rsp_command == CMD_ERASE)
      else $error("run does not open with erase");

   // a run continues without gaps and never repeats the erase
   a_run_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_command != CMD_ERASE)
      else $error("run broken or erase repeated");

   // nothing but a draw glyph carries a character
   a_glyph_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command != CMD_GLYPH |-> rsp_glyph == '0)
      else $error("glyph set on non-glyph command");

endmodule

bind text_console_cursor_controller tcc_checker u_checker (.*);

[tb/text_console_cursor_controller_tb.sv]
module text_console_cursor_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tcc_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int ITEMS_PER_SET = 38;
   localparam int SETTLE_CYCLES = 8;

   typedef struct {
      cmd_type                command;
      logic [POS_BITS-1:0]    x;
      logic [POS_BITS-1:0]    y;
      logic [CHAR_BITS-1:0]   glyph;
      logic [COLOR_BITS-1:0]  color;
      logic                   last;
   } draw_cmd_type;

   // Tracks the cursor and the console registers, and holds the drawing
   // commands still owed by the block.
   class draw_cmd_board_type;
      logic [SCREEN_BITS-1:0] col;
      logic [SCREEN_BITS-1:0] row;
      logic [SCREEN_BITS-1:0] width;
      logic [SCREEN_BITS-1:0] height;
      logic [TOP_BITS-1:0]    top;
      logic [COLOR_BITS-1:0]  fg;
      logic [COLOR_BITS-1:0]  bg;
      draw_cmd_type           owed_cmds[$];
      int                     errors;

      function new();
         col    = '0;
         row    = SCREEN_BITS'(RST_RESERVED_TOP);
         width  = RST_DISP_WIDTH;
         height = RST_DISP_HEIGHT;
         top    = RST_RESERVED_TOP;
         fg     = RST_TEXT_COLOR;
         bg     = RST_BACK_COLOR;
         errors = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] value);
         case (idx)
            REG_DISP_WIDTH:    width  = value[SCREEN_BITS-1:0];
            REG_DISP_HEIGHT:   height = value[SCREEN_BITS-1:0];
            REG_RESERVED_TOP:  top    = value[TOP_BITS-1:0];
            REG_TEXT_COLOR:    fg     = value;
            REG_BACK_COLOR:    bg     = value;
            default: ;
         endcase
      endfunction

      function draw_cmd_type make_cmd(cmd_type c, logic [SCREEN_BITS-1:0] px,
                                      logic [SCREEN_BITS-1:0] py,
                                      logic [CHAR_BITS-1:0] g,
                                      logic [COLOR_BITS-1:0] color);
         draw_cmd_type d;
         d.command = c;
         d.x       = px[POS_BITS-1:0];
         d.y       = py[POS_BITS-1:0];
         d.glyph   = g;
         d.color   = color;
         d.last    = 1'b0;
         return d;
      endfunction

      function void wrap_line();
         if (col + CELL_SIZE >= width) begin
            col = '0;
            row = SCREEN_BITS'(row + CELL_SIZE);
         end
      endfunction

      // Advance the cursor for one accepted character and queue its commands.
      function void take_char(logic [CHAR_BITS-1:0] code);
         draw_cmd_type run[$];
         bit           scroll_ok;
         scroll_ok = 1'b1;
         run.push_back(make_cmd(CMD_ERASE, col, row, '0, bg));
         case (code)
            CHAR_BS: begin
               if (col >= CELL_SIZE) col = SCREEN_BITS'(col - CELL_SIZE);
            end
            CHAR_TAB: begin
               col = SCREEN_BITS'(((col + TAB_STOP - 1) / TAB_STOP) * TAB_STOP);
               wrap_line();
            end
            CHAR_LF: begin
               row = SCREEN_BITS'(row + CELL_SIZE);
               col = '0;
            end
            CHAR_FF: begin
               run.push_back(make_cmd(CMD_CLEAR, '0, '0, '0, bg));
               col       = '0;
               row       = SCREEN_BITS'(top);
               scroll_ok = 1'b0;
            end
            CHAR_CR: begin
               col = '0;
            end
            default: begin
               if (code >= CHAR_PRINT_LO && code <= CHAR_PRINT_HI) begin
                  run.push_back(make_cmd(CMD_GLYPH, col, row, code, fg));
                  col = SCREEN_BITS'(col + CELL_SIZE);
                  wrap_line();
               end
            end
         endcase
         if (scroll_ok && row + 1 >= height) begin
            run.push_back(make_cmd(CMD_SCROLL, '0, SCREEN_BITS'(top), '0, bg));
            row = (row >= CELL_SIZE) ? SCREEN_BITS'(row - CELL_SIZE) : '0;
         end
         if (col < width && row < height)
            run.push_back(make_cmd(CMD_CURSOR, col, row, '0, fg));
         run[run.size()-1].last = 1'b1;
         foreach (run[i]) owed_cmds.push_back(run[i]);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_cmd(logic [2:0] command, logic [POS_BITS-1:0] px,
                              logic [POS_BITS-1:0] py, logic [CHAR_BITS-1:0] g,
                              logic [COLOR_BITS-1:0] color, logic last);
         draw_cmd_type d;
         if (owed_cmds.size() == 0) begin
            $display("%0t: command expected none actual cmd %0d x %0d y %0d", $time,
                     command, px, py);
            errors++;
         end else begin
            d = owed_cmds.pop_front();
            compare_field("command", 32'(d.command), 32'(command));
            compare_field("pos_x", 32'(d.x), 32'(px));
            compare_field("pos_y", 32'(d.y), 32'(py));
            compare_field("glyph", 32'(d.glyph), 32'(g));
            compare_field("pixel_color", d.color, color);
            compare_field("last", 32'(d.last), 32'(last));
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CHAR_BITS-1:0]  req_char_code = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [2:0]            rsp_command;
   logic [POS_BITS-1:0]   rsp_pos_x;
   logic [POS_BITS-1:0]   rsp_pos_y;
   logic [CHAR_BITS-1:0]  rsp_glyph;
   logic [COLOR_BITS-1:0] rsp_pixel_color;
   logic                  rsp_last;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [4:0]            paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   draw_cmd_board_type board;
   int  idle_pct = 0;
   bit  calm = 1'b0;
   int  stall_left = 0;
   int  quiet_cycles = 0;

   text_console_cursor_controller dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_code   (req_char_code),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_command     (rsp_command),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_glyph       (rsp_glyph),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Check each command transfer, watch for a hang, and drive rsp_ready.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_cmd(rsp_command, rsp_pos_x, rsp_pos_y, rsp_glyph,
                         rsp_pixel_color, rsp_last);
      if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("text_console_cursor_controller_tb: errors");
         $finish;
      end else begin
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic wait_drained();
      while (board.owed_cmds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_char(input logic [CHAR_BITS-1:0] code);
      int gap;
      req_valid     <= 1'b1;
      req_char_code <= code;
      do @(posedge clock); while (!req_ready);
      board.take_char(code);
      gap = 0;
      if (!calm && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 6);
      if (!calm && $urandom_range(0, 59) == 0) begin
         // hold off until the console has caught up
         req_valid <= 1'b0;
         wait_drained();
      end else if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.set_reg(idx, value);
   endtask

   task automatic apply_settings(input logic [SCREEN_BITS-1:0] w,
                                 input logic [SCREEN_BITS-1:0] h,
                                 input logic [TOP_BITS-1:0] top,
                                 input logic [COLOR_BITS-1:0] fg,
                                 input logic [COLOR_BITS-1:0] bg);
      write_reg(REG_DISP_WIDTH, 32'(w));
      write_reg(REG_DISP_HEIGHT, 32'(h));
      write_reg(REG_RESERVED_TOP, 32'(top));
      write_reg(REG_TEXT_COLOR, fg);
      write_reg(REG_BACK_COLOR, bg);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Mostly text and line breaks so that wrap and scroll come up often.
   function automatic logic [CHAR_BITS-1:0] pick_char();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return CHAR_BITS'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
      if (roll < 64) return CHAR_LF;
      if (roll < 70) return CHAR_BS;
      if (roll < 76) return CHAR_TAB;
      if (roll < 81) return CHAR_CR;
      if (roll < 84) return CHAR_FF;
      return CHAR_BITS'($urandom_range(0, 255));
   endfunction

   initial begin : stimulus
      logic [CHAR_BITS-1:0]   opening [0:16];
      logic [SCREEN_BITS-1:0] w;
      logic [SCREEN_BITS-1:0] h;
      logic [TOP_BITS-1:0]    top;
      logic [COLOR_BITS-1:0]  fg;
      logic [COLOR_BITS-1:0]  bg;
      board = new();
      opening = '{CHAR_BS, 8'd65, CHAR_PRINT_LO, CHAR_PRINT_HI, CHAR_BS, CHAR_TAB,
                  CHAR_TAB, CHAR_CR, CHAR_LF, 8'd0, 8'd31, 8'd127, 8'd128, 8'd255,
                  CHAR_FF, 8'd11, CHAR_LF};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 20;
      foreach (opening[i]) send_char(opening[i]);

      for (int phase = 0; phase < 7; phase++) begin
         req_valid <= 1'b0;
         wait_drained();
         fg = $urandom();
         bg = $urandom();
         case (phase)
            0: begin
               w = 13'd4096; h = 13'd4096; top = 7'd64; fg = '0; bg = '1;
               idle_pct = 30;
            end
            1: begin
               w = 13'd64; h = 13'd32; top = 7'd0; fg = '1; bg = '0;
               idle_pct = 10;
            end
            2: begin
               w = SCREEN_BITS'($urandom_range(64, 200));
               h = SCREEN_BITS'($urandom_range(32, 120));
               top = TOP_BITS'($urandom_range(0, 64));
               idle_pct = 0;
            end
            3: begin
               // text area starts below the visible screen
               w = 13'd72; h = 13'd48; top = 7'd64;
               idle_pct = 30;
            end
            4: begin
               w = SCREEN_BITS'($urandom_range(64, 320));
               h = SCREEN_BITS'($urandom_range(32, 200));
               top = TOP_BITS'($urandom_range(0, 64));
               idle_pct = 10;
            end
            5: begin
               w = 13'd4096; h = 13'd32; top = 7'd0;
               idle_pct = 30;
            end
            default: begin
               w = RST_DISP_WIDTH; h = RST_DISP_HEIGHT; top = RST_RESERVED_TOP;
               fg = RST_TEXT_COLOR; bg = RST_BACK_COLOR;
               calm = 1'b1;
            end
         endcase
         apply_settings(w, h, top, fg, bg);
         for (int n = 0; n < ITEMS_PER_SET; n++) send_char(pick_char());
      end

      req_valid <= 1'b0;
      wait_drained();
      if (board.owed_cmds.size() != 0) begin
         $display("%0t: %0d commands expected, none arrived", $time,
                  board.owed_cmds.size());
         board.errors++;
      end
      if (board.errors == 0) begin
         $display("text_console_cursor_controller_tb: clean");
      end else begin
         $display("text_console_cursor_controller_tb: errors");
      end
      $finish;
   end

endmodule
